@@ sv/first_fit_heap_allocator_core_defines.svh @@
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FFHA_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define FFHA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("allocator check failed");

`endif

@@ sv/ffha_pkg.sv @@
// Shared types and codes for the first-fit heap allocator.
// No dependencies; used by the interfaces, the header store and the top level.
package ffha_pkg;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_IGNORED     = 2'd1;
   localparam logic [1:0] ST_NO_MEMORY   = 2'd2;
   localparam logic [1:0] ST_BAD_POINTER = 2'd3;

   localparam int          NO_BLOCK_W = 15;
   localparam logic [14:0] NO_BLOCK   = 15'h7FFF;

   localparam int SIZE_W   = 16;
   localparam int OFFSET_W = 16;
   localparam int ALIGN_W  = 17;
   localparam int ALU_W    = 18;

   // Per-field write enables of the header store.
   typedef struct packed {
      logic size_we;
      logic free_we;
      logic mark_we;
      logic next_we;
      logic prev_we;
   } wr_en_type;

endpackage

@@ sv/ffha_ifs.sv @@
// Request and response channel interfaces of the allocator.
// Depends on ffha_pkg for field widths.
interface ffha_req_if import ffha_pkg::*;;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [SIZE_W-1:0]   request_bytes;
   logic [OFFSET_W-1:0] payload_offset;

   modport source (output valid, kind, request_bytes, payload_offset, input ready);
   modport sink   (input valid, kind, request_bytes, payload_offset, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*;;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [OFFSET_W-1:0] granted_offset;

   modport source (output valid, status, granted_offset, input ready);
   modport sink   (input valid, status, granted_offset, output ready);
endinterface

@@ sv/ffha_heap_mem.sv @@
// Block header store: size, free flag, mark and both links per header word.
// One write port with per-field enables, one registered read port. Uses ffha_pkg.
module ffha_heap_mem import ffha_pkg::*; #(
   parameter int DEPTH  = 16384,
   parameter int IDX_W  = 14,
   parameter int LINK_W = 15
) (
   input  logic              clock,
   input  wr_en_type         wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [SIZE_W-1:0] wr_size,
   input  logic              wr_free,
   input  logic              wr_mark,
   input  logic [LINK_W-1:0] wr_next,
   input  logic [LINK_W-1:0] wr_prev,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [SIZE_W-1:0] rd_size,
   output logic              rd_free,
   output logic              rd_mark,
   output logic [LINK_W-1:0] rd_next,
   output logic [LINK_W-1:0] rd_prev
);

   logic [SIZE_W-1:0] size_mem [DEPTH];
   logic              free_mem [DEPTH];
   logic              mark_mem [DEPTH];
   logic [LINK_W-1:0] next_mem [DEPTH];
   logic [LINK_W-1:0] prev_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en.size_we) size_mem[wr_addr] <= wr_size;
      if (wr_en.free_we) free_mem[wr_addr] <= wr_free;
      if (wr_en.mark_we) mark_mem[wr_addr] <= wr_mark;
      if (wr_en.next_we) next_mem[wr_addr] <= wr_next;
      if (wr_en.prev_we) prev_mem[wr_addr] <= wr_prev;
   end

   always_ff @(posedge clock) begin
      rd_size <= size_mem[rd_addr];
      rd_free <= free_mem[rd_addr];
      rd_mark <= mark_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
   end

endmodule

@@ sv/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator with coalescing over an arena of ARENA_BYTES.
// Channels: req_chan takes a request (kind 0 allocate request_bytes, kind 1 free
// payload_offset); rsp_chan returns one response per request (status and
// granted_offset). A request is taken when valid and ready are both high.
// After reset the block sweeps its header store, one entry a cycle, through all
// ARENA_BYTES/4 entries (16384 at the default) with req_chan.ready low.
// One request at a time: ready is high only while idle with no response pending.
// Allocate: a first-fit walk that, for each block visited, reads its header
// through the store's registered port and then checks it; then a split and
// commit, then the response is presented.
// Free: a header read, an optional merge with next and previous neighbor
// (each a read and one or two writes), then the response.
// Size sums and the split compare go through one shared adder.
// The response holds in rsp_chan while the receiver stalls; no new request is
// taken until it is delivered.
// Reset is synchronous, active high, and restarts the store sweep.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
   parameter int ARENA_BYTES  = 65536,
   parameter int HEADER_BYTES = 20
) (
   input  logic      clock,
   input  logic      reset,
   ffha_req_if.sink  req_chan,
   ffha_rsp_if.source rsp_chan
);

`include "first_fit_heap_allocator_core_defines.svh"

   localparam int DEPTH  = ARENA_BYTES / 4;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int LINK_W = (IDX_W > NO_BLOCK_W) ? IDX_W : NO_BLOCK_W;
   localparam int XW     = LINK_W + 2;
   localparam int STEP_W = IDX_W + 1;

   localparam logic [XW-1:0]     DEPTH_X   = XW'(DEPTH);
   localparam logic [SIZE_W-1:0] SIZE0     = SIZE_W'((ARENA_BYTES - HEADER_BYTES) % 65536);
   localparam logic [ALU_W-1:0]  HDR_A     = ALU_W'(HEADER_BYTES);
   localparam logic [ALU_W-1:0]  HDR4_A    = ALU_W'(HEADER_BYTES + 4);
   localparam logic [ALU_W-1:0]  NEG_HDR_A = ALU_W'((1 << ALU_W) - HEADER_BYTES);
   localparam logic [XW-1:0]     HDR_W_X   = XW'(HEADER_BYTES / 4);
   localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(NO_BLOCK);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_ARD, S_ACHK, S_AFIT, S_AWNEW, S_AWLINK, S_AWCUR,
      S_FRB, S_FCB, S_FRN, S_FCN, S_FWNP, S_FRP, S_FCP, S_FWPP,
      S_RESP
   } state_type;

   function automatic logic linked(input logic [LINK_W-1:0] l);
      return (l != NO_LINK) && (XW'(l) < DEPTH_X);
   endfunction

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      clr_ff, clr_in;
   logic [ALIGN_W-1:0]    aligned_ff, aligned_in;
   logic [LINK_W-1:0]     cur_ff, cur_in;
   logic [STEP_W-1:0]     steps_ff, steps_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [LINK_W-1:0]     nxt_ff, nxt_in;
   logic [LINK_W-1:0]     prv_ff, prv_in;
   logic [LINK_W-1:0]     ni_ff, ni_in;
   logic                  split_ff, split_in;
   logic [1:0]            status_ff, status_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;

   wr_en_type             wr_en;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [SIZE_W-1:0]     wr_size, rd_size;
   logic                  wr_free, wr_mark, rd_free, rd_mark;
   logic [LINK_W-1:0]     wr_next, wr_prev, rd_next, rd_prev;

   logic [ALU_W-1:0]      alu_a, alu_b, alu_c, alu_sum;
   logic                  alu_cin;

   logic [ALIGN_W-1:0]    req_aligned;
   logic [OFFSET_W-1:0]   req_hdr;
   logic                  req_bad_ptr;
   logic [XW-1:0]         ni_x;
   logic [XW-1:0]         grant_x;
   logic [LINK_W-1:0]     p_eff;

   ffha_heap_mem #(
      .DEPTH  (DEPTH),
      .IDX_W  (IDX_W),
      .LINK_W (LINK_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_size (wr_size),
      .wr_free (wr_free),
      .wr_mark (wr_mark),
      .wr_next (wr_next),
      .wr_prev (wr_prev),
      .rd_addr (rd_addr),
      .rd_size (rd_size),
      .rd_free (rd_free),
      .rd_mark (rd_mark),
      .rd_next (rd_next),
      .rd_prev (rd_prev)
   );

   // Shared adder: split threshold, split remainder and merge sums.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_c   = '0;
      alu_cin = 1'b0;
      unique case (state_ff)
         S_AFIT: begin
            alu_a = ALU_W'(aligned_ff);
            alu_c = HDR4_A;
         end
         S_AWNEW: begin
            alu_a   = ALU_W'(size_ff);
            alu_b   = ~ALU_W'(aligned_ff);
            alu_c   = NEG_HDR_A;
            alu_cin = 1'b1;
         end
         S_FCN: begin
            alu_a = ALU_W'(size_ff);
            alu_b = ALU_W'(rd_size);
            alu_c = HDR_A;
         end
         S_FCP: begin
            alu_a = ALU_W'(rd_size);
            alu_b = ALU_W'(size_ff);
            alu_c = HDR_A;
         end
         default: begin
         end
      endcase
   end

   assign alu_sum = alu_a + alu_b + alu_c + ALU_W'(alu_cin);

   assign req_aligned = (ALIGN_W'(req_chan.request_bytes) + ALIGN_W'(3)) & ~ALIGN_W'(3);
   assign req_hdr     = req_chan.payload_offset - OFFSET_W'(HEADER_BYTES);
   assign req_bad_ptr = (32'(req_chan.payload_offset) < 32'(HEADER_BYTES))
                        || (req_hdr[1:0] != 2'b00)
                        || (XW'(req_hdr[OFFSET_W-1:2]) >= DEPTH_X);
   assign ni_x    = XW'(cur_ff) + HDR_W_X + XW'(aligned_ff[ALIGN_W-1:2]);
   assign grant_x = (XW'(cur_ff) << 2) + XW'(HEADER_BYTES);
   assign p_eff   = (nxt_ff == cur_ff) ? cur_ff : prv_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      aligned_in = aligned_ff;
      cur_in    = cur_ff;
      steps_in  = steps_ff;
      size_in   = size_ff;
      nxt_in    = nxt_ff;
      prv_in    = prv_ff;
      ni_in     = ni_ff;
      split_in  = split_ff;
      status_in = status_ff;
      offset_in = offset_ff;

      wr_en   = '0;
      wr_addr = cur_ff[IDX_W-1:0];
      wr_size = '0;
      wr_free = 1'b0;
      wr_mark = 1'b0;
      wr_next = NO_LINK;
      wr_prev = NO_LINK;
      rd_addr = cur_ff[IDX_W-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = '{size_we: 1'b1, free_we: 1'b1, mark_we: 1'b1,
                        next_we: 1'b1, prev_we: 1'b1};
            wr_addr = clr_ff;
            wr_size = (clr_ff == '0) ? SIZE0 : '0;
            wr_free = (clr_ff == '0);
            wr_mark = (clr_ff == '0);
            clr_in  = clr_ff + IDX_W'(1);
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            offset_in = '0;
            if (req_chan.valid) begin
               if (req_chan.kind == KIND_ALLOC) begin
                  aligned_in = req_aligned;
                  cur_in     = '0;
                  steps_in   = '0;
                  if (req_chan.request_bytes == '0) begin
                     status_in = ST_IGNORED;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_ARD;
                  end
               end else begin
                  cur_in = LINK_W'(req_hdr[OFFSET_W-1:2]);
                  if (req_chan.payload_offset == '0) begin
                     status_in = ST_IGNORED;
                     state_in  = S_RESP;
                  end else if (req_bad_ptr) begin
                     status_in = ST_BAD_POINTER;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_FRB;
                  end
               end
            end
         end
         S_ARD: begin
            state_in = S_ACHK;
         end
         S_ACHK: begin
            size_in = rd_size;
            nxt_in  = rd_next;
            if (!rd_mark) begin
               status_in = ST_NO_MEMORY;
               state_in  = S_RESP;
            end else if (rd_free && (ALIGN_W'(rd_size) >= aligned_ff)) begin
               state_in = S_AFIT;
            end else begin
               // advance the walk; stop at a dead link or after a full pass
               steps_in = steps_ff + STEP_W'(1);
               cur_in   = rd_next;
               if ((XW'(steps_ff) + XW'(1) >= DEPTH_X) || !linked(rd_next)) begin
                  status_in = ST_NO_MEMORY;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_ARD;
               end
            end
         end
         S_AFIT: begin
            split_in = (ALU_W'(size_ff) > alu_sum) && (ni_x < DEPTH_X);
            ni_in    = ni_x[LINK_W-1:0];
            state_in = ((ALU_W'(size_ff) > alu_sum) && (ni_x < DEPTH_X)) ? S_AWNEW : S_AWCUR;
         end
         S_AWNEW: begin
            wr_en   = '{size_we: 1'b1, free_we: 1'b1, mark_we: 1'b1,
                        next_we: 1'b1, prev_we: 1'b1};
            wr_addr = ni_ff[IDX_W-1:0];
            wr_size = alu_sum[SIZE_W-1:0];
            wr_free = 1'b1;
            wr_mark = 1'b1;
            wr_next = nxt_ff;
            wr_prev = cur_ff;
            state_in = linked(nxt_ff) ? S_AWLINK : S_AWCUR;
         end
         S_AWLINK: begin
            wr_en.prev_we = 1'b1;
            wr_addr       = nxt_ff[IDX_W-1:0];
            wr_prev       = ni_ff;
            state_in      = S_AWCUR;
         end
         S_AWCUR: begin
            wr_en.free_we = 1'b1;
            wr_en.size_we = split_ff;
            wr_en.next_we = split_ff;
            wr_free       = 1'b0;
            wr_size       = aligned_ff[SIZE_W-1:0];
            wr_next       = ni_ff;
            status_in     = ST_OK;
            offset_in     = grant_x[OFFSET_W-1:0];
            state_in      = S_RESP;
         end
         S_FRB: begin
            state_in = S_FCB;
         end
         S_FCB: begin
            size_in = rd_size;
            nxt_in  = rd_next;
            prv_in  = rd_prev;
            if (!rd_mark) begin
               status_in = ST_BAD_POINTER;
               state_in  = S_RESP;
            end else begin
               wr_en.free_we = 1'b1;
               wr_free       = 1'b1;
               status_in     = ST_OK;
               if (linked(rd_next)) begin
                  state_in = S_FRN;
               end else if (linked(rd_prev)) begin
                  state_in = S_FRP;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_FRN: begin
            rd_addr  = nxt_ff[IDX_W-1:0];
            state_in = S_FCN;
         end
         S_FCN: begin
            if (rd_free) begin
               // absorb the next block
               wr_en.size_we = 1'b1;
               wr_en.next_we = 1'b1;
               wr_size       = alu_sum[SIZE_W-1:0];
               wr_next       = rd_next;
               size_in       = alu_sum[SIZE_W-1:0];
               nxt_in        = rd_next;
               if (linked(rd_next)) begin
                  state_in = S_FWNP;
               end else begin
                  state_in = linked(prv_ff) ? S_FRP : S_RESP;
               end
            end else begin
               state_in = linked(prv_ff) ? S_FRP : S_RESP;
            end
         end
         S_FWNP: begin
            wr_en.prev_we = 1'b1;
            wr_addr       = nxt_ff[IDX_W-1:0];
            wr_prev       = cur_ff;
            // a self-linked chain also rewrites this block's own back link
            prv_in        = p_eff;
            state_in      = linked(p_eff) ? S_FRP : S_RESP;
         end
         S_FRP: begin
            rd_addr  = prv_ff[IDX_W-1:0];
            state_in = S_FCP;
         end
         S_FCP: begin
            if (rd_free) begin
               wr_en.size_we = 1'b1;
               wr_en.next_we = 1'b1;
               wr_addr       = prv_ff[IDX_W-1:0];
               wr_size       = alu_sum[SIZE_W-1:0];
               wr_next       = nxt_ff;
               state_in      = linked(nxt_ff) ? S_FWPP : S_RESP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FWPP: begin
            wr_en.prev_we = 1'b1;
            wr_addr       = nxt_ff[IDX_W-1:0];
            wr_prev       = prv_ff;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      aligned_ff <= aligned_in;
      cur_ff     <= cur_in;
      steps_ff   <= steps_in;
      size_ff    <= size_in;
      nxt_ff     <= nxt_in;
      prv_ff     <= prv_in;
      ni_ff      <= ni_in;
      split_ff   <= split_in;
      status_ff  <= status_in;
      offset_ff  <= offset_in;
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = (state_ff == S_RESP);
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.granted_offset = offset_ff;

   `FFHA_ASSERT_NOW(a_no_overlap, clock, reset, rsp_chan.valid, !req_chan.ready)
   `FFHA_ASSERT_NOW(a_grant_only_ok, clock, reset,
      rsp_chan.valid && (rsp_chan.status != ST_OK), rsp_chan.granted_offset == '0)
   `FFHA_ASSERT_NEXT(a_busy_after_take, clock, reset,
      req_chan.valid && req_chan.ready, !req_chan.ready)
   `FFHA_ASSERT_NOW(a_idle_no_write, clock, reset, req_chan.ready, wr_en == '0)

endmodule

@@ sim/first_fit_heap_allocator_core_test.sv @@
// Self-checking test of the first-fit heap allocator core: directed corner requests,
// then random allocate/free traffic checked against a heap model kept in the test.
// Depends on ffha_pkg, the ffha_req_if/ffha_rsp_if interfaces and the core itself.
module first_fit_heap_allocator_core_test;
   import ffha_pkg::*;

   localparam int ARENA_BYTES    = 65536;
   localparam int HEADER_BYTES   = 20;
   localparam int DEPTH          = ARENA_BYTES / 4;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int MAX_LIVE       = 40;
   localparam int RANDOM_OPS     = 300;

   typedef struct packed {
      logic [1:0]          status;
      logic [OFFSET_W-1:0] granted_offset;
   } heap_rsp_type;

   // Heap model plus the queue of responses it still waits for.
   class heap_ledger;
      logic [SIZE_W-1:0]     size_of [DEPTH];
      bit                    is_free [DEPTH];
      bit                    marked  [DEPTH];
      logic [NO_BLOCK_W-1:0] next_of [DEPTH];
      logic [NO_BLOCK_W-1:0] prev_of [DEPTH];
      heap_rsp_type          awaited [$];
      int                    mismatches;

      function new();
         int i;
         for (i = 0; i < DEPTH; i++) begin
            size_of[i] = '0;
            is_free[i] = 1'b0;
            marked[i]  = 1'b0;
            next_of[i] = NO_BLOCK;
            prev_of[i] = NO_BLOCK;
         end
         size_of[0] = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
         is_free[0] = 1'b1;
         marked[0]  = 1'b1;
         mismatches = 0;
      endfunction

      function bit linked(int unsigned link);
         return link != NO_BLOCK && link < DEPTH;
      endfunction

      function heap_rsp_type predict_alloc(int unsigned bytes);
         heap_rsp_type r;
         int unsigned  need, cur, steps, split;
         r.status         = ST_NO_MEMORY;
         r.granted_offset = '0;
         if (bytes == 0) begin
            r.status = ST_IGNORED;
            return r;
         end
         need = (bytes + 3) & ~32'd3;
         cur  = 0;
         for (steps = 0; steps < DEPTH && linked(cur); steps++) begin
            if (!marked[cur])
               break;
            if (is_free[cur] && size_of[cur] >= need) begin
               if (size_of[cur] > need + HEADER_BYTES + 4) begin
                  split = (cur * 4 + HEADER_BYTES + need) >> 2;
                  // no split when the new header would fall outside the arena
                  if (split < DEPTH) begin
                     marked[split]  = 1'b1;
                     is_free[split] = 1'b1;
                     size_of[split] = SIZE_W'(size_of[cur] - need - HEADER_BYTES);
                     next_of[split] = next_of[cur];
                     prev_of[split] = NO_BLOCK_W'(cur);
                     if (linked(next_of[cur]))
                        prev_of[next_of[cur]] = NO_BLOCK_W'(split);
                     next_of[cur] = NO_BLOCK_W'(split);
                     size_of[cur] = SIZE_W'(need);
                  end
               end
               is_free[cur]     = 1'b0;
               r.status         = ST_OK;
               r.granted_offset = OFFSET_W'(cur * 4 + HEADER_BYTES);
               return r;
            end
            cur = next_of[cur];
         end
         return r;
      endfunction

      function heap_rsp_type predict_release(int unsigned ptr);
         heap_rsp_type r;
         int unsigned  hdr, b, n, p, nb;
         r.status         = ST_OK;
         r.granted_offset = '0;
         if (ptr == 0) begin
            r.status = ST_IGNORED;
            return r;
         end
         if (ptr < HEADER_BYTES) begin
            r.status = ST_BAD_POINTER;
            return r;
         end
         hdr = ptr - HEADER_BYTES;
         b   = hdr >> 2;
         if ((hdr & 3) != 0 || b >= DEPTH || !marked[b]) begin
            r.status = ST_BAD_POINTER;
            return r;
         end
         is_free[b] = 1'b1;
         // absorb a free successor, then fold into a free predecessor
         n = next_of[b];
         if (linked(n) && is_free[n]) begin
            size_of[b] = SIZE_W'(size_of[b] + size_of[n] + HEADER_BYTES);
            next_of[b] = next_of[n];
            if (linked(next_of[b]))
               prev_of[next_of[b]] = NO_BLOCK_W'(b);
         end
         p = prev_of[b];
         if (linked(p) && is_free[p]) begin
            size_of[p] = SIZE_W'(size_of[p] + size_of[b] + HEADER_BYTES);
            nb         = next_of[b];
            next_of[p] = NO_BLOCK_W'(nb);
            if (linked(nb))
               prev_of[nb] = NO_BLOCK_W'(p);
         end
         return r;
      endfunction

      function heap_rsp_type record_request(logic kind, logic [SIZE_W-1:0] bytes,
                                            logic [OFFSET_W-1:0] ptr);
         heap_rsp_type r;
         if (kind == KIND_ALLOC)
            r = predict_alloc(32'(bytes));
         else
            r = predict_release(32'(ptr));
         awaited.push_back(r);
         return r;
      endfunction

      function void check_response(logic [1:0] status, logic [OFFSET_W-1:0] granted);
         heap_rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response expected none actual status %0d offset %0d",
                     $time, status, granted);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
         end
         if (granted !== want.granted_offset) begin
            $display("%0t: granted_offset expected %0d actual %0d",
                     $time, want.granted_offset, granted);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   heap_ledger  ledger;
   int          send_idle_pct = 38;
   int          recv_idle_pct = 61;
   int unsigned idle_cycles   = 0;
   int unsigned live_ptrs [$];

   ffha_req_if req_chan ();
   ffha_rsp_if rsp_chan ();

   first_fit_heap_allocator_core #(
      .ARENA_BYTES (ARENA_BYTES),
      .HEADER_BYTES(HEADER_BYTES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response side: stall at random, change at the falling edge
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         ledger.check_response(rsp_chan.status, rsp_chan.granted_offset);
   end

   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("first_fit_heap_allocator_core_test: FAIL");
         $finish;
      end
   end

   task automatic send_request(logic kind, logic [SIZE_W-1:0] bytes,
                               logic [OFFSET_W-1:0] ptr);
      heap_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid          = 1'b1;
      req_chan.kind           = kind;
      req_chan.request_bytes  = bytes;
      req_chan.payload_offset = ptr;
      @(posedge clock);
      while (req_chan.ready !== 1'b1)
         @(posedge clock);
      predicted = ledger.record_request(kind, bytes, ptr);
      if (kind == KIND_ALLOC && predicted.status == ST_OK)
         live_ptrs.push_back(32'(predicted.granted_offset));
      @(negedge clock);
   endtask

   // hold off new requests until every response is back
   task automatic drain_responses();
      req_chan.valid = 1'b0;
      while (ledger.awaited.size() != 0)
         @(negedge clock);
   endtask

   task automatic free_live(int unsigned idx);
      int unsigned ptr;
      ptr = live_ptrs[idx];
      live_ptrs.delete(idx);
      send_request(KIND_FREE, SIZE_W'($urandom), OFFSET_W'(ptr));
   endtask

   task automatic random_op();
      int unsigned roll, ptr, hdr;
      roll = $urandom_range(99);
      if (roll < 8) begin
         ptr = ($urandom_range(3) == 0) ? $urandom_range(HEADER_BYTES - 1)
                                        : $urandom_range(65535);
         hdr = ptr - HEADER_BYTES;
         // keep noise off real headers: a stray hit would free a block behind our back
         if (ptr >= HEADER_BYTES && (hdr & 3) == 0 && (hdr >> 2) < DEPTH &&
             ledger.marked[hdr >> 2])
            ptr = ptr ^ 1;
         send_request(KIND_FREE, SIZE_W'($urandom), OFFSET_W'(ptr));
      end else if (roll < 11) begin
         send_request(KIND_ALLOC, SIZE_W'($urandom), OFFSET_W'($urandom));
      end else if (roll < 13) begin
         send_request(KIND_ALLOC, '0, OFFSET_W'($urandom));
      end else if (roll < 15) begin
         send_request(KIND_FREE, SIZE_W'($urandom), '0);
      end else if (live_ptrs.size() > 0 && (roll < 55 || live_ptrs.size() >= MAX_LIVE)) begin
         free_live($urandom_range(live_ptrs.size() - 1));
      end else if (roll < 60) begin
         send_request(KIND_ALLOC, SIZE_W'($urandom_range(1, 4096)), OFFSET_W'($urandom));
      end else begin
         send_request(KIND_ALLOC, SIZE_W'($urandom_range(1, 512)), OFFSET_W'($urandom));
      end
   endtask

   task automatic random_phase(int send_pct, int recv_pct);
      int i;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (i = 0; i < RANDOM_OPS; i++)
         random_op();
   endtask

   initial begin
      int unsigned blk_a, blk_b;
      ledger                  = new();
      req_chan.valid          = 1'b0;
      req_chan.kind           = KIND_ALLOC;
      req_chan.request_bytes  = '0;
      req_chan.payload_offset = '0;
      reset                   = 1'b1;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // corners of both request kinds from a fresh arena
      send_request(KIND_ALLOC, '0, 16'hFFFF);
      send_request(KIND_ALLOC, 16'hFFFF, '0);
      send_request(KIND_ALLOC, SIZE_W'(ARENA_BYTES - HEADER_BYTES), '0);
      send_request(KIND_ALLOC, 16'd1, '0);
      send_request(KIND_FREE, 16'hFFFF, '0);
      send_request(KIND_FREE, '0, OFFSET_W'(HEADER_BYTES - 1));
      send_request(KIND_FREE, '0, OFFSET_W'(HEADER_BYTES + 2));
      send_request(KIND_FREE, '0, 16'hFFFF);
      send_request(KIND_FREE, '0, OFFSET_W'(HEADER_BYTES + 4));
      send_request(KIND_FREE, '0, OFFSET_W'(HEADER_BYTES));
      send_request(KIND_FREE, '0, OFFSET_W'(HEADER_BYTES));
      // remainder of exactly one header plus a word: no split
      send_request(KIND_ALLOC, SIZE_W'(ARENA_BYTES - 2 * HEADER_BYTES - 4), '0);
      send_request(KIND_FREE, '0, OFFSET_W'(HEADER_BYTES));
      live_ptrs.delete();
      send_request(KIND_ALLOC, 16'd1, 16'hFFFF);
      send_request(KIND_ALLOC, 16'd100, '0);
      send_request(KIND_ALLOC, 16'd7, '0);
      send_request(KIND_FREE, '0, OFFSET_W'(live_ptrs[1]));
      send_request(KIND_FREE, '0, OFFSET_W'(live_ptrs[0]));
      send_request(KIND_FREE, '0, OFFSET_W'(live_ptrs[2]));
      send_request(KIND_ALLOC, 16'd3, '0);
      send_request(KIND_FREE, 16'hFFFF, OFFSET_W'(live_ptrs[3]));
      live_ptrs.delete();
      drain_responses();

      random_phase(38, 61);
      drain_responses();
      random_phase(61, 38);
      drain_responses();
      random_phase(0, 0);

      // stale and double frees last, since they may leave the chain corrupt
      while (live_ptrs.size() > 0)
         free_live(live_ptrs.size() - 1);
      send_request(KIND_ALLOC, 16'd40, '0);
      send_request(KIND_ALLOC, 16'd40, '0);
      send_request(KIND_ALLOC, 16'd40, '0);
      blk_a = live_ptrs[0];
      blk_b = live_ptrs[1];
      live_ptrs.delete();
      send_request(KIND_FREE, '0, OFFSET_W'(blk_b));
      send_request(KIND_FREE, '0, OFFSET_W'(blk_a));
      send_request(KIND_FREE, '0, OFFSET_W'(blk_b));
      send_request(KIND_FREE, '0, OFFSET_W'(blk_a));
      repeat (12) random_op();

      drain_responses();
      repeat (64) @(posedge clock);
      if (ledger.mismatches == 0)
         $display("first_fit_heap_allocator_core_test: PASS");
      else
         $display("first_fit_heap_allocator_core_test: FAIL");
      $finish;
   end

endmodule
